// File: rtl/core/sgi_pkg.sv
// Shared widths, types and pipeline sizes for the segment intersection block.
`timescale 1ns / 1ps

package sgi_pkg;

  // Coordinate width; all coordinates share one fixed-point format.
  localparam int COORD_W      = 24;
  // Edge differences, cross products, determinant sums and their magnitudes.
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int MAG_W        = PROD_W;
  // Running value inside one division cell: 2*rem + numerator < 3*det.
  localparam int REM_X        = MAG_W + 2;
  // Stream payload widths.
  localparam int IN_DATA_W    = 8 * COORD_W;
  localparam int OUT_DATA_W   = 2 * COORD_W;
  // Pipeline: front-end stages, one cell per quotient bit, one output stage.
  localparam int FRONT_STAGES = 5;
  localparam int N_CELLS      = COORD_W;
  localparam int PIPE_STAGES  = FRONT_STAGES + N_CELLS + 1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [COORD_W-1:0] ucoord_t;

  // Payload handed from cell to cell along the division chain.
  typedef struct packed {
    logic    hit;
    coord_t  a0_re;
    coord_t  a0_im;
    logic    neg_re;
    logic    neg_im;
    mag_t    det_mag;
    mag_t    sn_mag;
    ucoord_t d_re;
    ucoord_t d_im;
    ucoord_t q_re;
    ucoord_t q_im;
    mag_t    r_re;
    mag_t    r_im;
  } cell_t;

endpackage

// File: rtl/core/sgi_front.sv
// Front end: edge differences, cross products, determinants and the range test.
`timescale 1ns / 1ps

module sgi_front import sgi_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  logic [IN_DATA_W-1:0]    in_data,
  output cell_t                   cell_o
);

  coord_t pt [8];

  // Stage 1: differences.
  coord_t a0_re_r, a0_im_r;
  diff_t  dax_r, day_r, dbx_r, dby_r, wx_r, wy_r;
  // Stage 2: products.
  coord_t s2_a0_re_r, s2_a0_im_r;
  diff_t  s2_dax_r, s2_day_r;
  prod_t  p_det0_r, p_det1_r, p_sn0_r, p_sn1_r, p_un0_r, p_un1_r;
  // Stage 3: determinant and numerators.
  coord_t s3_a0_re_r, s3_a0_im_r;
  diff_t  s3_dax_r, s3_day_r;
  sum_t   det_r, sn_r, un_r;
  // Stage 4: signs and magnitudes.
  coord_t  s4_a0_re_r, s4_a0_im_r;
  logic    det_neg_r, sn_neg_r, un_neg_r, dax_neg_r, day_neg_r;
  mag_t    det_mag_r, sn_mag_r, un_mag_r;
  ucoord_t dax_mag_r, day_mag_r;
  // Stage 5: range test, start of the division chain.
  cell_t   cell_r, cell_nxt;
  logic    sn_ok, un_ok;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pt[i] = in_data[i*COORD_W +: COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_re_r <= pt[0];
      a0_im_r <= pt[1];
      dax_r   <= DIFF_W'(pt[2]) - DIFF_W'(pt[0]);
      day_r   <= DIFF_W'(pt[3]) - DIFF_W'(pt[1]);
      dbx_r   <= DIFF_W'(pt[6]) - DIFF_W'(pt[4]);
      dby_r   <= DIFF_W'(pt[7]) - DIFF_W'(pt[5]);
      wx_r    <= DIFF_W'(pt[4]) - DIFF_W'(pt[0]);
      wy_r    <= DIFF_W'(pt[5]) - DIFF_W'(pt[1]);
    end
    if (en[1]) begin
      s2_a0_re_r <= a0_re_r;
      s2_a0_im_r <= a0_im_r;
      s2_dax_r   <= dax_r;
      s2_day_r   <= day_r;
      p_det0_r   <= PROD_W'(dbx_r) * PROD_W'(day_r);
      p_det1_r   <= PROD_W'(dax_r) * PROD_W'(dby_r);
      p_sn0_r    <= PROD_W'(dbx_r) * PROD_W'(wy_r);
      p_sn1_r    <= PROD_W'(dby_r) * PROD_W'(wx_r);
      p_un0_r    <= PROD_W'(dax_r) * PROD_W'(wy_r);
      p_un1_r    <= PROD_W'(day_r) * PROD_W'(wx_r);
    end
    if (en[2]) begin
      s3_a0_re_r <= s2_a0_re_r;
      s3_a0_im_r <= s2_a0_im_r;
      s3_dax_r   <= s2_dax_r;
      s3_day_r   <= s2_day_r;
      det_r      <= SUM_W'(p_det0_r) - SUM_W'(p_det1_r);
      sn_r       <= SUM_W'(p_sn0_r) - SUM_W'(p_sn1_r);
      un_r       <= SUM_W'(p_un0_r) - SUM_W'(p_un1_r);
    end
    if (en[3]) begin
      s4_a0_re_r <= s3_a0_re_r;
      s4_a0_im_r <= s3_a0_im_r;
      det_neg_r  <= det_r[SUM_W-1];
      sn_neg_r   <= sn_r[SUM_W-1];
      un_neg_r   <= un_r[SUM_W-1];
      dax_neg_r  <= s3_dax_r[DIFF_W-1];
      day_neg_r  <= s3_day_r[DIFF_W-1];
      det_mag_r  <= MAG_W'(det_r[SUM_W-1] ? -det_r : det_r);
      sn_mag_r   <= MAG_W'(sn_r[SUM_W-1] ? -sn_r : sn_r);
      un_mag_r   <= MAG_W'(un_r[SUM_W-1] ? -un_r : un_r);
      dax_mag_r  <= COORD_W'(s3_dax_r[DIFF_W-1] ? -s3_dax_r : s3_dax_r);
      day_mag_r  <= COORD_W'(s3_day_r[DIFF_W-1] ? -s3_day_r : s3_day_r);
    end
    if (en[4]) begin
      cell_r <= cell_nxt;
    end
  end

  // A ratio lies in [0, 1] when the numerator is zero, or when it has the
  // determinant's sign and no larger magnitude.
  always_comb begin
    sn_ok = (sn_mag_r == '0) || ((sn_neg_r == det_neg_r) && (sn_mag_r <= det_mag_r));
    un_ok = (un_mag_r == '0) || ((un_neg_r == det_neg_r) && (un_mag_r <= det_mag_r));
    cell_nxt         = '0;
    cell_nxt.hit     = (det_mag_r != '0) && sn_ok && un_ok;
    cell_nxt.a0_re   = s4_a0_re_r;
    cell_nxt.a0_im   = s4_a0_im_r;
    cell_nxt.neg_re  = sn_neg_r ^ det_neg_r ^ dax_neg_r;
    cell_nxt.neg_im  = sn_neg_r ^ det_neg_r ^ day_neg_r;
    cell_nxt.det_mag = det_mag_r;
    cell_nxt.sn_mag  = sn_mag_r;
    cell_nxt.d_re    = dax_mag_r;
    cell_nxt.d_im    = day_mag_r;
  end

  assign cell_o = cell_r;

endmodule

// File: rtl/core/sgi_cell.sv
// One cell of the division chain: one quotient bit of |sn|*|d| / |det| per component.
`timescale 1ns / 1ps

module sgi_cell import sgi_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cell_t cell_i,
  output cell_t cell_o
);

  cell_t cell_r, cell_nxt;

  // Folds the next multiplier bit into the running product and reduces it
  // by the determinant; the remainder stays below the determinant, so the
  // new quotient digit is 0, 1 or 2.
  function automatic logic [COORD_W+MAG_W-1:0] div_step(
    input ucoord_t q,
    input mag_t    r,
    input logic    b,
    input mag_t    sn,
    input mag_t    det
  );
    logic [REM_X-1:0] x;
    logic [REM_X:0]   s1;
    logic [REM_X:0]   s2;
    ucoord_t          q_n;
    mag_t             r_n;
    x  = REM_X'({r, 1'b0}) + (b ? REM_X'(sn) : REM_X'(0));
    s1 = {1'b0, x} - (REM_X + 1)'(det);
    s2 = {1'b0, x} - (REM_X + 1)'({det, 1'b0});
    priority if (!s2[REM_X]) begin
      q_n = {q[COORD_W-2:0], 1'b0} + COORD_W'(2);
      r_n = s2[MAG_W-1:0];
    end else if (!s1[REM_X]) begin
      q_n = {q[COORD_W-2:0], 1'b1};
      r_n = s1[MAG_W-1:0];
    end else begin
      q_n = {q[COORD_W-2:0], 1'b0};
      r_n = x[MAG_W-1:0];
    end
    return {q_n, r_n};
  endfunction

  always_comb begin
    cell_nxt = cell_i;
    {cell_nxt.q_re, cell_nxt.r_re} = div_step(cell_i.q_re, cell_i.r_re,
                                              cell_i.d_re[COORD_W-1],
                                              cell_i.sn_mag, cell_i.det_mag);
    {cell_nxt.q_im, cell_nxt.r_im} = div_step(cell_i.q_im, cell_i.r_im,
                                              cell_i.d_im[COORD_W-1],
                                              cell_i.sn_mag, cell_i.det_mag);
    cell_nxt.d_re = {cell_i.d_re[COORD_W-2:0], 1'b0};
    cell_nxt.d_im = {cell_i.d_im[COORD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

// File: rtl/core/segment_intersection_2d.sv
// Top level of the segment intersection block: front end, division chain, output register.
// Throughput: one request per cycle unless the output stalls and the pipeline is full.
// Stages: 5 front-end stages, one division cell per quotient bit (24), one output register.
// Reset: synchronous, active low; it clears only the stage valid bits, payload is not reset.
`timescale 1ns / 1ps

module segment_intersection_2d import sgi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0 up: a_start_re, a_start_im, a_end_re, a_end_im,
  // b_start_re, b_start_im, b_end_re, b_end_im (24 bits each, signed).
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0 up: cross_re, cross_im (24 bits each, signed).
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Field: hit.
  output logic                  out_tuser
);

  // One valid bit per pipeline stage; the last one belongs to the output
  // register. A stage may load when it is empty or when everything after it
  // can move, so bubbles are squeezed out while the output is stalled.
  logic [PIPE_STAGES-1:0] v_r, v_nxt;
  logic [PIPE_STAGES-1:0] en;

  // The division chain: chain[0] comes from the front end, chain[k+1] from cell k.
  cell_t chain [N_CELLS+1];

  logic   hit_r, hit_nxt;
  coord_t cross_re_r, cross_re_nxt;
  coord_t cross_im_r, cross_im_nxt;
  cell_t  last;

  genvar gi;
  generate
    for (gi = 0; gi < PIPE_STAGES; gi++) begin : g_en
      assign en[gi] = out_tready | ~(&v_r[PIPE_STAGES-1:gi]);
    end
  endgenerate

  assign in_tready = en[0];

  always_comb begin
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < PIPE_STAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Differences, cross products, determinant, numerators and the exact range test.
  sgi_front u_front (
    .clk    (clk),
    .en     (en[FRONT_STAGES-1:0]),
    .in_data(in_tdata),
    .cell_o (chain[0])
  );

  // Each cell takes one bit of |d|, most significant first, and builds the
  // quotient trunc(|sn|*|d| / |det|) one digit at a time. Because |sn| does
  // not exceed |det| on a hit, the quotient fits the coordinate width.
  generate
    for (gi = 0; gi < N_CELLS; gi++) begin : g_cell
      sgi_cell u_cell (
        .clk   (clk),
        .en    (en[FRONT_STAGES+gi]),
        .cell_i(chain[gi]),
        .cell_o(chain[gi+1])
      );
    end
  endgenerate

  // The point is A0 plus or minus the quotient; it lies between A0 and A1,
  // so it never leaves the coordinate range. Misses report zero.
  assign last = chain[N_CELLS];

  always_comb begin
    hit_nxt      = last.hit;
    cross_re_nxt = '0;
    cross_im_nxt = '0;
    if (last.hit) begin
      cross_re_nxt = last.neg_re ? coord_t'(last.a0_re - last.q_re)
                                 : coord_t'(last.a0_re + last.q_re);
      cross_im_nxt = last.neg_im ? coord_t'(last.a0_im - last.q_im)
                                 : coord_t'(last.a0_im + last.q_im);
    end
  end

  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES-1]) begin
      hit_r      <= hit_nxt;
      cross_re_r <= cross_re_nxt;
      cross_im_r <= cross_im_nxt;
    end
  end

  assign out_tvalid = v_r[PIPE_STAGES-1];
  assign out_tuser  = hit_r;
  assign out_tdata  = {cross_im_r, cross_re_r};

`ifndef SYNTH
  // A miss always carries a zero point.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero point");

  // An accepted request lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted request lost at entry");

  // While the output is stalled no item can leave the pipeline.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_tvalid && !out_tready
    |=> $countones(v_r) >= $past($countones(v_r)))
    else $error("item dropped during output stall");

  // At most one item enters and one leaves per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) <= $past($countones(v_r)) + 1) &&
                     ($countones(v_r) + 1 >= $past($countones(v_r))))
    else $error("pipeline occupancy jumped");
`endif

endmodule
